// ===== design/target_validity_and_steering_core_assert.svh =====
// assertion macros for the target validity and steering core
`ifndef TARGET_VALIDITY_AND_STEERING_CORE_ASSERT_SVH
`define TARGET_VALIDITY_AND_STEERING_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// consequent must hold in the same cycle as the antecedent
`define TVSC_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");
// consequent must hold in the cycle after the antecedent
`define TVSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");
`else
`define TVSC_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define TVSC_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== design/tvs_pkg.sv =====
package tvs_pkg;

    // signed pixel coordinate
    typedef logic signed [12:0] coord_t;

    // largest absolute difference of two coordinates
    localparam int CoordAbsMax = 8191;

    // bus widths
    localparam int S_TDATA_W = 144;
    localparam int M_TDATA_W = 56;

    // input item, last field (corner0_x) in the lowest bits
    typedef struct packed {
        logic [11:0] column_offset;
        logic [9:0]  distance_cm;
        logic [15:0] keypoint_count;
        coord_t      corner3_y;
        coord_t      corner3_x;
        coord_t      corner2_y;
        coord_t      corner2_x;
        coord_t      corner1_y;
        coord_t      corner1_x;
        coord_t      corner0_y;
        coord_t      corner0_x;
    } in_item_t;

    // result item, last field (detected) in the lowest bits
    typedef struct packed {
        logic [15:0]        jitter_sum;
        logic [15:0]        perimeter;
        logic signed [15:0] kp_threshold;
        logic               too_near;
        logic               forward;
        logic [1:0]         steer;
        logic               detected;
    } out_item_t;

    localparam int IN_ITEM_W  = $bits(in_item_t);
    localparam int OUT_ITEM_W = $bits(out_item_t);

    // register indexes
    localparam logic [2:0] REG_IMAGE_HALF_WIDTH = 3'd0;
    localparam logic [2:0] REG_THRESHOLD_MODE   = 3'd1;
    localparam logic [2:0] REG_MIN_PERIMETER    = 3'd2;
    localparam logic [2:0] REG_MAX_JITTER       = 3'd3;
    localparam logic [2:0] REG_NEAR_PERIMETER   = 3'd4;
    localparam logic [2:0] REG_MIN_DISTANCE     = 3'd5;
    localparam logic [2:0] REG_THRESHOLD_INIT   = 3'd6;

    // register reset values
    localparam logic [11:0]        RST_IMAGE_HALF_WIDTH = 12'd320;
    localparam logic [1:0]         RST_THRESHOLD_MODE   = 2'd0;
    localparam logic [15:0]        RST_MIN_PERIMETER    = 16'd100;
    localparam logic [15:0]        RST_MAX_JITTER       = 16'd400;
    localparam logic [15:0]        RST_NEAR_PERIMETER   = 16'd1000;
    localparam logic [9:0]         RST_MIN_DISTANCE     = 10'd15;
    localparam logic signed [15:0] RST_THRESHOLD_INIT   = 16'sd0;

    // threshold modes
    localparam logic [1:0] THR_MODE_AUTO       = 2'd0;
    localparam logic [1:0] THR_MODE_ACCURACY   = 2'd1;
    localparam logic [1:0] THR_MODE_THROUGHPUT = 2'd2;

    // keypoint count bounds per effective mode
    localparam logic [15:0] KEYS_ACC_LOW  = 16'd1500;
    localparam logic [15:0] KEYS_ACC_HIGH = 16'd2000;
    localparam logic [15:0] KEYS_THR_LOW  = 16'd100;
    localparam logic [15:0] KEYS_THR_HIGH = 16'd200;

    // threshold limits
    localparam logic signed [15:0] THR_MIN = 16'sh8000;
    localparam logic signed [15:0] THR_MAX = 16'sh7FFF;

    // steer codes
    localparam logic [1:0] STEER_NONE  = 2'd0;
    localparam logic [1:0] STEER_LEFT  = 2'd1;
    localparam logic [1:0] STEER_RIGHT = 2'd2;

    // control from the decision logic to the threshold unit
    typedef struct packed {
        logic        step;
        logic        detected;
        logic [1:0]  mode;
        logic [15:0] keys;
    } thr_req_t;

    // absolute difference of two coordinates
    function automatic logic [12:0] tvs_absdiff(input coord_t a, input coord_t b);
        logic signed [13:0] d;
        d = 14'(a) - 14'(b);
        return d[13] ? 13'(-d) : 13'(d);
    endfunction

endpackage

// ===== design/tvs_perimeter.sv =====
module tvs_perimeter (
    input  tvs_pkg::coord_t [3:0] cx,
    input  tvs_pkg::coord_t [3:0] cy,
    output logic [15:0]           perimeter
);

    // manhattan perimeter around the quadrilateral; eight terms of at most
    // 8191 each stay below 65536, so the sum never needs clamping
    always_comb begin
        perimeter = '0;
        for (int i = 0; i < 4; i++) begin
            perimeter = perimeter
                + 16'(tvs_pkg::tvs_absdiff(cx[i], cx[(i + 1) % 4]))
                + 16'(tvs_pkg::tvs_absdiff(cy[i], cy[(i + 1) % 4]));
        end
    end

endmodule

// ===== design/tvs_history.sv =====
module tvs_history #(
    parameter int HISTORY_FRAMES = 3
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  tvs_pkg::coord_t [3:0] cx,
    output logic                  warm,
    output logic [15:0]           jitter_sum
);

    localparam int Slots = HISTORY_FRAMES - 1;
    localparam int FsW   = $clog2(HISTORY_FRAMES + 1);
    localparam int JsW   = $clog2(Slots * 4 * tvs_pkg::CoordAbsMax + 1) + 1;

    tvs_pkg::coord_t [Slots-1:0][3:0] hist_reg;
    tvs_pkg::coord_t [Slots:0][3:0]   seq;
    logic [FsW-1:0]                   frames_reg;
    logic [JsW-1:0]                   jsum;

    assign warm = (frames_reg >= FsW'(HISTORY_FRAMES));

    // oldest frame first, current frame on top
    always_comb begin
        seq[Slots] = cx;
        for (int k = 0; k < Slots; k++) begin
            seq[k] = hist_reg[k];
        end
    end

    // x change between neighboring frames, summed over the window
    always_comb begin
        jsum = '0;
        for (int k = 0; k < Slots; k++) begin
            for (int i = 0; i < 4; i++) begin
                jsum = jsum + JsW'(tvs_pkg::tvs_absdiff(seq[k+1][i], seq[k][i]));
            end
        end
    end

    // clamp, and zero during warm-up
    always_comb begin
        if (!warm) begin
            jitter_sum = '0;
        end else if (jsum > JsW'(16'hFFFF)) begin
            jitter_sum = 16'hFFFF;
        end else begin
            jitter_sum = jsum[15:0];
        end
    end

    // history shift and saturating frame count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_reg   <= '0;
            frames_reg <= '0;
        end else if (step) begin
            for (int k = 0; k < Slots - 1; k++) begin
                hist_reg[k] <= hist_reg[k+1];
            end
            hist_reg[Slots-1] <= cx;
            if (!warm) begin
                frames_reg <= frames_reg + FsW'(1);
            end
        end
    end

endmodule

// ===== design/tvs_threshold.sv =====
module tvs_threshold (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  tvs_pkg::thr_req_t       req,
    input  logic                    load,
    input  logic signed [15:0]      load_value,
    output logic signed [15:0]      threshold_next
);

    logic signed [15:0] thr_reg;
    logic               accuracy;
    logic               dec;
    logic               inc;

    // effective mode; the unused code behaves as auto
    always_comb begin
        unique case (req.mode)
            tvs_pkg::THR_MODE_ACCURACY:   accuracy = 1'b1;
            tvs_pkg::THR_MODE_THROUGHPUT: accuracy = 1'b0;
            default:                      accuracy = !req.detected;
        endcase
    end

    // nudge direction from the keypoint count
    assign dec = accuracy ? (req.keys < tvs_pkg::KEYS_ACC_LOW)
                          : (req.keys < tvs_pkg::KEYS_THR_LOW);
    assign inc = accuracy ? (req.keys > tvs_pkg::KEYS_ACC_HIGH)
                          : (req.keys > tvs_pkg::KEYS_THR_HIGH);

    // saturating step by one
    always_comb begin
        if (dec) begin
            threshold_next = (thr_reg > tvs_pkg::THR_MIN) ? thr_reg - 16'sd1 : thr_reg;
        end else if (inc) begin
            threshold_next = (thr_reg < tvs_pkg::THR_MAX) ? thr_reg + 16'sd1 : thr_reg;
        end else begin
            threshold_next = thr_reg;
        end
    end

    // running threshold, reloaded on a write of the initial value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= tvs_pkg::RST_THRESHOLD_INIT;
        end else if (load) begin
            thr_reg <= load_value;
        end else if (req.step) begin
            thr_reg <= threshold_next;
        end
    end

endmodule

// ===== design/target_validity_and_steering_core.sv =====
// a result reaches m_tdata through the input register and the result register;
// that stage, and with it the item rate below, stalls while m_tready is low
// throughput: one frame item per cycle; the next item enters while a result waits
// the rate is set by the single pass from the input register to the result register
// reset (aresetn low, synchronous): both stages empty, registers to defaults,
// history and frame count cleared, running threshold back to its default
`include "target_validity_and_steering_core_assert.svh"

module target_validity_and_steering_core #(
    parameter int HISTORY_FRAMES = 3
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // corner0_x, corner0_y, corner1_x, corner1_y, corner2_x, corner2_y,
    // corner3_x, corner3_y, keypoint_count, distance_cm, column_offset, zero pad
    input  logic [tvs_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // detected, steer, forward, too_near, kp_threshold, perimeter,
    // jitter_sum, zero pad
    output logic [tvs_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [2:0]                      cfg_index,
    input  logic [15:0]                     cfg_data
);

    tvs_pkg::in_item_t  in_reg;
    logic               in_valid_reg;
    tvs_pkg::out_item_t out_reg;
    tvs_pkg::out_item_t result;
    logic               out_valid_reg;
    logic               adv;

    logic [11:0]        ihw_reg;
    logic [1:0]         mode_reg;
    logic [15:0]        min_perim_reg;
    logic [15:0]        max_jitter_reg;
    logic [15:0]        near_perim_reg;
    logic [9:0]         min_dist_reg;

    tvs_pkg::coord_t [3:0] cx;
    tvs_pkg::coord_t [3:0] cy;
    logic [15:0]        perim;
    logic [15:0]        jitter;
    logic               hist_warm;
    logic               detected;
    logic signed [13:0] span;
    logic signed [13:0] span_adj;
    logic signed [13:0] half_span;
    logic signed [14:0] mid;
    logic [12:0]        center;
    logic signed [15:0] mid_w;
    logic signed [15:0] center_w;
    logic               cfg_xfer;
    logic signed [15:0] thr_next;
    tvs_pkg::thr_req_t  thr_req;

    // handshake: the result stage moves when empty or being taken
    assign adv       = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || adv;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = tvs_pkg::M_TDATA_W'(out_reg);
    assign cfg_ready = 1'b1;
    assign cfg_xfer  = cfg_valid && cfg_ready;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg <= tvs_pkg::in_item_t'(s_tdata[tvs_pkg::IN_ITEM_W-1:0]);
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ihw_reg        <= tvs_pkg::RST_IMAGE_HALF_WIDTH;
            mode_reg       <= tvs_pkg::RST_THRESHOLD_MODE;
            min_perim_reg  <= tvs_pkg::RST_MIN_PERIMETER;
            max_jitter_reg <= tvs_pkg::RST_MAX_JITTER;
            near_perim_reg <= tvs_pkg::RST_NEAR_PERIMETER;
            min_dist_reg   <= tvs_pkg::RST_MIN_DISTANCE;
        end else if (cfg_xfer) begin
            unique case (cfg_index)
                tvs_pkg::REG_IMAGE_HALF_WIDTH: ihw_reg        <= cfg_data[11:0];
                tvs_pkg::REG_THRESHOLD_MODE:   mode_reg       <= cfg_data[1:0];
                tvs_pkg::REG_MIN_PERIMETER:    min_perim_reg  <= cfg_data;
                tvs_pkg::REG_MAX_JITTER:       max_jitter_reg <= cfg_data;
                tvs_pkg::REG_NEAR_PERIMETER:   near_perim_reg <= cfg_data;
                tvs_pkg::REG_MIN_DISTANCE:     min_dist_reg   <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // corner unpacking
    assign cx = {in_reg.corner3_x, in_reg.corner2_x, in_reg.corner1_x, in_reg.corner0_x};
    assign cy = {in_reg.corner3_y, in_reg.corner2_y, in_reg.corner1_y, in_reg.corner0_y};

    tvs_perimeter u_perimeter (
        .cx        (cx),
        .cy        (cy),
        .perimeter (perim)
    );

    tvs_history #(
        .HISTORY_FRAMES (HISTORY_FRAMES)
    ) u_history (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (adv),
        .cx         (cx),
        .warm       (hist_warm),
        .jitter_sum (jitter)
    );

    // validity test
    assign detected = hist_warm && (perim >= min_perim_reg) && (jitter <= max_jitter_reg);

    // midpoint of corners 0 and 1, half span truncated toward zero
    assign span      = 14'(in_reg.corner1_x) - 14'(in_reg.corner0_x);
    assign span_adj  = span[13] ? span + 14'sd1 : span;
    assign half_span = span_adj >>> 1;
    assign mid       = 15'(half_span) + 15'(in_reg.corner0_x);
    assign center    = 13'(in_reg.column_offset) + 13'(ihw_reg);
    assign mid_w     = 16'(mid);
    assign center_w  = signed'({3'b000, center});

    // threshold unit control
    assign thr_req.step     = adv;
    assign thr_req.detected = detected;
    assign thr_req.mode     = mode_reg;
    assign thr_req.keys     = in_reg.keypoint_count;

    tvs_threshold u_threshold (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .req            (thr_req),
        .load           (cfg_xfer && (cfg_index == tvs_pkg::REG_THRESHOLD_INIT)),
        .load_value     (signed'(cfg_data)),
        .threshold_next (thr_next)
    );

    // result assembly
    always_comb begin
        result.detected     = detected;
        result.steer        = tvs_pkg::STEER_NONE;
        result.forward      = 1'b0;
        result.too_near     = 1'b0;
        result.kp_threshold = thr_next;
        result.perimeter    = perim;
        result.jitter_sum   = jitter;
        if (detected) begin
            if (mid_w < center_w) begin
                result.steer = tvs_pkg::STEER_LEFT;
            end else if (mid_w > center_w) begin
                result.steer = tvs_pkg::STEER_RIGHT;
            end
            if (perim < near_perim_reg) begin
                result.forward  = (in_reg.distance_cm > min_dist_reg);
                result.too_near = !(in_reg.distance_cm > min_dist_reg);
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= result;
        end
    end

    // checks
    `TVSC_ASSERT_NOW(a_no_steer_without_detect, aclk, aresetn,
        m_tvalid && !out_reg.detected,
        out_reg.steer == tvs_pkg::STEER_NONE && !out_reg.forward && !out_reg.too_near)
    `TVSC_ASSERT_NOW(a_forward_near_exclusive, aclk, aresetn,
        m_tvalid, !(out_reg.forward && out_reg.too_near))
    `TVSC_ASSERT_NEXT(a_warmup_quiet, aclk, aresetn,
        adv && !hist_warm, out_reg.jitter_sum == 16'd0 && !out_reg.detected)

endmodule

// ===== sim/target_validity_and_steering_core_tb.sv =====
`timescale 1ns / 1ps

module target_validity_and_steering_core_tb;

    localparam int TRACK_DEPTH = 3;
    localparam int HIST_SLOTS = TRACK_DEPTH - 1;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 10;
    // index with no register behind it, writes are ignored
    localparam logic [2:0] REG_UNUSED = 3'd7;
    // mode code with no mode behind it, behaves as auto
    localparam logic [1:0] THR_MODE_UNUSED = 2'd3;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic [tvs_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [tvs_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [2:0]                    cfg_index = '0;
    logic [15:0]                   cfg_data = '0;

    // frames waiting for the driver and verdicts waiting for the monitor
    tvs_pkg::in_item_t  frames_pending[$];
    tvs_pkg::out_item_t verdicts_due[$];
    int                 frames_queued = 0;
    int                 frames_taken = 0;
    int                 mismatches = 0;
    int                 cycles = 0;
    int                 idle_pct = 0;
    int                 src_gap = 0;
    int                 sink_gap = 0;
    tvs_pkg::out_item_t mon_want;
    tvs_pkg::out_item_t mon_got;

    // tracked target for the random frames
    int trk_x = 0;
    int trk_y = 0;
    int trk_w = 100;
    int trk_h = 100;

    // shadow copy of the block's registers and state
    logic [11:0]        cfg_half;
    logic [1:0]         cfg_mode;
    logic [15:0]        cfg_min_perim;
    logic [15:0]        cfg_max_jitter;
    logic [15:0]        cfg_near;
    logic [9:0]         cfg_min_dist;
    logic signed [15:0] run_thr;
    int                 hist_x[HIST_SLOTS][4];
    int                 frames_seen;

    always #5 aclk = ~aclk;

    target_validity_and_steering_core #(
        .HISTORY_FRAMES(TRACK_DEPTH)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tdata(s_tdata),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata(m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    function automatic int span(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic int clip(input int v, input int lo, input int hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int pick_in(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // expected result of one frame, advances the shadow state
    function automatic tvs_pkg::out_item_t frame_verdict(input tvs_pkg::in_item_t f);
        int                 cx[4];
        int                 cy[4];
        int                 perim;
        int                 jit;
        int                 nxt;
        int                 mid;
        int                 off;
        logic               hit;
        logic               accuracy;
        logic               go_down;
        logic               go_up;
        tvs_pkg::out_item_t v;
        cx[0] = f.corner0_x;
        cy[0] = f.corner0_y;
        cx[1] = f.corner1_x;
        cy[1] = f.corner1_y;
        cx[2] = f.corner2_x;
        cy[2] = f.corner2_y;
        cx[3] = f.corner3_x;
        cy[3] = f.corner3_y;
        v = '0;
        perim = 0;
        jit = 0;
        hit = 1'b0;
        for (int i = 0; i < 4; i++)
            perim += span(cx[i], cx[(i + 1) % 4]) + span(cy[i], cy[(i + 1) % 4]);
        perim = clip(perim, 0, 65535);

        // jitter only once the history is full
        if (frames_seen >= TRACK_DEPTH) begin
            for (int k = 0; k < HIST_SLOTS; k++) begin
                for (int i = 0; i < 4; i++) begin
                    nxt = (k + 1 < HIST_SLOTS) ? hist_x[k + 1][i] : cx[i];
                    jit += span(nxt, hist_x[k][i]);
                end
            end
            jit = clip(jit, 0, 65535);
            hit = (perim >= int'(cfg_min_perim)) && (jit <= int'(cfg_max_jitter));
        end else begin
            frames_seen++;
        end
        for (int k = 0; k + 1 < HIST_SLOTS; k++)
            hist_x[k] = hist_x[k + 1];
        for (int i = 0; i < 4; i++)
            hist_x[HIST_SLOTS - 1][i] = cx[i];

        // steering and range decision
        v.steer = tvs_pkg::STEER_NONE;
        if (hit) begin
            mid = (cx[1] - cx[0]) / 2 + cx[0];
            off = mid - (int'(f.column_offset) + int'(cfg_half));
            if (off < 0)
                v.steer = tvs_pkg::STEER_LEFT;
            else if (off > 0)
                v.steer = tvs_pkg::STEER_RIGHT;
            if (perim < int'(cfg_near)) begin
                if (f.distance_cm > cfg_min_dist)
                    v.forward = 1'b1;
                else
                    v.too_near = 1'b1;
            end
        end

        // running threshold nudge
        case (cfg_mode)
            tvs_pkg::THR_MODE_ACCURACY: accuracy = 1'b1;
            tvs_pkg::THR_MODE_THROUGHPUT: accuracy = 1'b0;
            default: accuracy = !hit;
        endcase
        go_down = accuracy ? (f.keypoint_count < tvs_pkg::KEYS_ACC_LOW)
                           : (f.keypoint_count < tvs_pkg::KEYS_THR_LOW);
        go_up = accuracy ? (f.keypoint_count > tvs_pkg::KEYS_ACC_HIGH)
                         : (f.keypoint_count > tvs_pkg::KEYS_THR_HIGH);
        if (go_down) begin
            if (run_thr != tvs_pkg::THR_MIN)
                run_thr = run_thr - 16'sd1;
        end else if (go_up) begin
            if (run_thr != tvs_pkg::THR_MAX)
                run_thr = run_thr + 16'sd1;
        end

        v.detected = hit;
        v.kp_threshold = run_thr;
        v.perimeter = 16'(perim);
        v.jitter_sum = 16'(jit);
        return v;
    endfunction

    function automatic tvs_pkg::in_item_t quad(input int x0, input int y0,
                                               input int x1, input int y1,
                                               input int x2, input int y2,
                                               input int x3, input int y3,
                                               input int keys, input int range_cm,
                                               input int coff);
        tvs_pkg::in_item_t f;
        f.corner0_x = tvs_pkg::coord_t'(x0);
        f.corner0_y = tvs_pkg::coord_t'(y0);
        f.corner1_x = tvs_pkg::coord_t'(x1);
        f.corner1_y = tvs_pkg::coord_t'(y1);
        f.corner2_x = tvs_pkg::coord_t'(x2);
        f.corner2_y = tvs_pkg::coord_t'(y2);
        f.corner3_x = tvs_pkg::coord_t'(x3);
        f.corner3_y = tvs_pkg::coord_t'(y3);
        f.keypoint_count = 16'(keys);
        f.distance_cm = 10'(range_cm);
        f.column_offset = 12'(coff);
        return f;
    endfunction

    function automatic tvs_pkg::in_item_t rect(input int xa, input int xb,
                                               input int ya, input int yb,
                                               input int keys, input int range_cm,
                                               input int coff);
        return quad(xa, ya, xb, ya, xb, yb, xa, yb, keys, range_cm, coff);
    endfunction

    task automatic add_frame(input tvs_pkg::in_item_t f);
        frames_pending = {frames_pending, f};
        frames_queued++;
    endtask

    // random frame: mostly a slowly drifting quadrilateral, some noise
    task automatic make_frame(output tvs_pkg::in_item_t f);
        int xs[4];
        int ys[4];
        int pick;
        int keys;
        int range_cm;
        int coff;
        logic tracked;
        pick = pick_in(0, 99);
        tracked = (pick >= 20) || (pick < 8);
        if (pick < 8) begin
            trk_x = pick_in(-3000, 3000);
            trk_y = pick_in(-3000, 3000);
            trk_w = (pick_in(0, 9) == 0) ? pick_in(0, 3000) : pick_in(0, 400);
            trk_h = (pick_in(0, 9) == 0) ? pick_in(0, 3000) : pick_in(0, 400);
        end
        if (!tracked) begin
            for (int i = 0; i < 4; i++) begin
                xs[i] = pick_in(-4096, 4095);
                ys[i] = pick_in(-4096, 4095);
            end
        end else begin
            trk_x = clip(trk_x + pick_in(-10, 10), -4096, 4095);
            xs[0] = trk_x;
            xs[1] = trk_x + trk_w;
            xs[2] = trk_x + trk_w;
            xs[3] = trk_x;
            ys[0] = trk_y;
            ys[1] = trk_y;
            ys[2] = trk_y + trk_h;
            ys[3] = trk_y + trk_h;
            for (int i = 0; i < 4; i++) begin
                xs[i] = clip(xs[i] + pick_in(-3, 3), -4096, 4095);
                ys[i] = clip(ys[i] + pick_in(-3, 3), -4096, 4095);
            end
        end
        case (pick_in(0, 3))
            0: keys = pick_in(0, 250);
            1: keys = pick_in(1400, 2100);
            default: keys = pick_in(0, 65535);
        endcase
        range_cm = pick_in(0, 1) ? pick_in(0, 40) : pick_in(0, 1023);
        // aim the center reference near the midpoint so all steer codes occur
        if (tracked && pick_in(0, 9) < 6)
            coff = clip((xs[1] - xs[0]) / 2 + xs[0] - int'(cfg_half) + pick_in(-2, 2),
                        0, 4095);
        else
            coff = pick_in(0, 4095);
        f = quad(xs[0], ys[0], xs[1], ys[1], xs[2], ys[2], xs[3], ys[3],
                 keys, range_cm, coff);
    endtask

    // register write while the block is idle, shadow copy follows
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            tvs_pkg::REG_IMAGE_HALF_WIDTH: cfg_half = val[11:0];
            tvs_pkg::REG_THRESHOLD_MODE: cfg_mode = val[1:0];
            tvs_pkg::REG_MIN_PERIMETER: cfg_min_perim = val;
            tvs_pkg::REG_MAX_JITTER: cfg_max_jitter = val;
            tvs_pkg::REG_NEAR_PERIMETER: cfg_near = val;
            tvs_pkg::REG_MIN_DISTANCE: cfg_min_dist = val[9:0];
            tvs_pkg::REG_THRESHOLD_INIT: run_thr = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        while (!(frames_taken == frames_queued && verdicts_due.size() == 0))
            @(posedge aclk);
    endtask

    task automatic run_phase(input int n, input int idle);
        tvs_pkg::in_item_t f;
        idle_pct = idle;
        repeat (n) begin
            make_frame(f);
            add_frame(f);
        end
        drain();
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_gap = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                verdicts_due = {verdicts_due, frame_verdict(
                    tvs_pkg::in_item_t'(s_tdata[tvs_pkg::IN_ITEM_W-1:0]))};
                frames_taken++;
            end
            // a frame not yet taken stays on the bus
            if (!(s_tvalid && !s_tready)) begin
                if (idle_pct > 0 && src_gap > 0) begin
                    s_tvalid <= 1'b0;
                    src_gap--;
                end else if (idle_pct > 0 && pick_in(0, 99) < idle_pct) begin
                    src_gap = pick_in(1, 13) - 1;
                    s_tvalid <= 1'b0;
                end else if (frames_pending.size() > 0) begin
                    s_tdata <= tvs_pkg::S_TDATA_W'(frames_pending[0]);
                    s_tvalid <= 1'b1;
                    frames_pending.delete(0);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (verdicts_due.size() == 0) begin
                    $display("%0t: result with no frame pending, expected none, got %h",
                             $time, m_tdata);
                    mismatches++;
                end else begin
                    mon_want = verdicts_due[0];
                    verdicts_due.delete(0);
                    mon_got = tvs_pkg::out_item_t'(m_tdata[tvs_pkg::OUT_ITEM_W-1:0]);
                    check_field("detected", mon_want.detected, mon_got.detected);
                    check_field("steer", mon_want.steer, mon_got.steer);
                    check_field("forward", mon_want.forward, mon_got.forward);
                    check_field("too_near", mon_want.too_near, mon_got.too_near);
                    check_field("kp_threshold", mon_want.kp_threshold,
                                mon_got.kp_threshold);
                    check_field("perimeter", mon_want.perimeter, mon_got.perimeter);
                    check_field("jitter_sum", mon_want.jitter_sum, mon_got.jitter_sum);
                end
            end
            if (idle_pct > 0 && sink_gap > 0) begin
                m_tready <= 1'b0;
                sink_gap--;
            end else if (idle_pct > 0 && pick_in(0, 99) < idle_pct) begin
                sink_gap = pick_in(1, 13) - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("target_validity_and_steering_core_tb: FAIL");
            $finish;
        end
    end

    initial begin
        cfg_half = tvs_pkg::RST_IMAGE_HALF_WIDTH;
        cfg_mode = tvs_pkg::RST_THRESHOLD_MODE;
        cfg_min_perim = tvs_pkg::RST_MIN_PERIMETER;
        cfg_max_jitter = tvs_pkg::RST_MAX_JITTER;
        cfg_near = tvs_pkg::RST_NEAR_PERIMETER;
        cfg_min_dist = tvs_pkg::RST_MIN_DISTANCE;
        run_thr = tvs_pkg::RST_THRESHOLD_INIT;
        frames_seen = 0;
        for (int k = 0; k < HIST_SLOTS; k++)
            for (int i = 0; i < 4; i++)
                hist_x[k][i] = 0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed frames under reset settings
        idle_pct = 20;
        // warm-up with coordinate extremes
        add_frame(rect(-4096, -4096, -4096, -4096, 0, 0, 0));
        add_frame(rect(4095, 4095, 4095, 4095, 65535, 1023, 4095));
        add_frame(rect(350, 450, 0, 100, 1499, 16, 0));
        // history still holds the big jump, then settles
        add_frame(rect(350, 450, 0, 100, 1500, 16, 0));
        add_frame(rect(350, 450, 0, 100, 2000, 16, 0));
        // steady target: right and forward, none and too near, left
        add_frame(rect(350, 450, 0, 100, 2001, 16, 0));
        add_frame(rect(350, 450, 0, 100, 99, 15, 80));
        add_frame(rect(350, 450, 0, 100, 201, 1023, 4095));
        add_frame(rect(350, 450, 0, 100, 150, 0, 0));
        // negative odd midpoint difference truncates toward zero
        add_frame(quad(451, 0, 448, 0, 450, 100, 350, 100, 100, 500, 130));
        // large target, no forward
        add_frame(rect(350, 450, 0, 2000, 100, 500, 0));
        // perimeter below the minimum
        add_frame(rect(350, 360, 0, 10, 200, 500, 0));
        add_frame(rect(350, 450, 0, 100, 1600, 500, 0));
        // jitter over the limit, then back within it
        add_frame(rect(410, 510, 0, 100, 1600, 500, 0));
        add_frame(rect(410, 510, 0, 100, 3000, 500, 0));
        // widest perimeters
        add_frame(rect(-4096, 4095, -4096, 4095, 0, 1023, 4095));
        add_frame(quad(-4096, -4096, 4095, 4095, -4096, -4096, 4095, 4095, 65535, 0, 0));
        add_frame(quad(-4096, -4096, 4095, 4095, -4096, -4096, 4095, 4095, 65535, 0, 0));
        drain();

        write_reg(tvs_pkg::REG_THRESHOLD_MODE, 16'(tvs_pkg::THR_MODE_THROUGHPUT));
        write_reg(tvs_pkg::REG_NEAR_PERIMETER, 16'd1500);
        run_phase(105, 25);

        // permissive extremes, threshold pinned at the top
        write_reg(tvs_pkg::REG_IMAGE_HALF_WIDTH, 16'd0);
        write_reg(tvs_pkg::REG_THRESHOLD_MODE, 16'(tvs_pkg::THR_MODE_ACCURACY));
        write_reg(tvs_pkg::REG_MIN_PERIMETER, 16'd0);
        write_reg(tvs_pkg::REG_MAX_JITTER, 16'hFFFF);
        write_reg(tvs_pkg::REG_NEAR_PERIMETER, 16'hFFFF);
        write_reg(tvs_pkg::REG_MIN_DISTANCE, 16'd0);
        write_reg(tvs_pkg::REG_THRESHOLD_INIT, tvs_pkg::THR_MAX);
        add_frame(rect(0, 10, 0, 10, 65535, 0, 0));
        add_frame(rect(0, 10, 0, 10, 65535, 1, 0));
        run_phase(105, 10);

        // strict extremes, threshold pinned at the bottom
        write_reg(tvs_pkg::REG_IMAGE_HALF_WIDTH, 16'd2048);
        write_reg(tvs_pkg::REG_THRESHOLD_MODE, 16'(tvs_pkg::THR_MODE_THROUGHPUT));
        write_reg(tvs_pkg::REG_MIN_PERIMETER, 16'hFFFF);
        write_reg(tvs_pkg::REG_MAX_JITTER, 16'd0);
        write_reg(tvs_pkg::REG_NEAR_PERIMETER, 16'd0);
        write_reg(tvs_pkg::REG_MIN_DISTANCE, 16'd1023);
        write_reg(tvs_pkg::REG_THRESHOLD_INIT, tvs_pkg::THR_MIN);
        add_frame(rect(0, 10, 0, 10, 0, 1023, 0));
        add_frame(rect(0, 10, 0, 10, 0, 1023, 0));
        run_phase(105, 40);

        // unused mode code behaves as auto
        write_reg(tvs_pkg::REG_THRESHOLD_MODE, 16'(THR_MODE_UNUSED));
        write_reg(tvs_pkg::REG_IMAGE_HALF_WIDTH, 16'(tvs_pkg::RST_IMAGE_HALF_WIDTH));
        write_reg(tvs_pkg::REG_MIN_PERIMETER, 16'd100);
        write_reg(tvs_pkg::REG_MAX_JITTER, 16'd300);
        write_reg(tvs_pkg::REG_NEAR_PERIMETER, 16'd1000);
        write_reg(tvs_pkg::REG_MIN_DISTANCE, 16'd15);
        write_reg(tvs_pkg::REG_THRESHOLD_INIT, 16'(pick_in(0, 65535)));
        run_phase(105, 15);

        // random settings
        write_reg(tvs_pkg::REG_IMAGE_HALF_WIDTH, 16'(pick_in(0, 2048)));
        write_reg(tvs_pkg::REG_THRESHOLD_MODE, 16'(tvs_pkg::THR_MODE_AUTO));
        write_reg(tvs_pkg::REG_MIN_PERIMETER, 16'(pick_in(0, 2000)));
        write_reg(tvs_pkg::REG_MAX_JITTER, 16'(pick_in(0, 1000)));
        write_reg(tvs_pkg::REG_NEAR_PERIMETER, 16'(pick_in(0, 6000)));
        write_reg(tvs_pkg::REG_MIN_DISTANCE, 16'(pick_in(0, 1023)));
        write_reg(tvs_pkg::REG_THRESHOLD_INIT, 16'(pick_in(0, 65535)));
        write_reg(REG_UNUSED, 16'(pick_in(0, 65535)));
        run_phase(105, 30);

        // closing stretch at full rate
        write_reg(tvs_pkg::REG_MIN_PERIMETER, 16'd100);
        write_reg(tvs_pkg::REG_MAX_JITTER, 16'd400);
        write_reg(tvs_pkg::REG_NEAR_PERIMETER, 16'd1000);
        write_reg(tvs_pkg::REG_MIN_DISTANCE, 16'd15);
        run_phase(105, 0);

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("target_validity_and_steering_core_tb: PASS");
        else
            $display("target_validity_and_steering_core_tb: FAIL");
        $finish;
    end

endmodule
